// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define PCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== design/pcp_pkg.sv =====
`timescale 1ns / 1ps

package pcp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PCNT_W     = 10;
  localparam int WFIRST_W   = 10;
  localparam int WEND_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int CHARGE_W = 35;
  localparam int PEAK_W   = 25;
  localparam int STATUS_W = 2;

  localparam int SUM_W = 27;

  // Dividend width of the rounding dividers, with margin over the largest magnitude.
  localparam int DIV_W = 46;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PED_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 2'd2;

  localparam logic [PCNT_W-1:0]   PED_COUNT_RST = 10'd100;
  localparam logic [WFIRST_W-1:0] WIN_FIRST_RST = 10'd150;
  localparam logic [WEND_W-1:0]   WIN_END_RST   = 11'd350;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_WINDOW   = 2'd1,
    STATUS_PEDESTAL = 2'd2
  } status_e;

  typedef struct packed {
    status_e                     status;
    logic [PCNT_W-1:0]           ped_n;
    logic signed [SUM_W-1:0]     ped_sum;
    logic [WEND_W-1:0]           win_len;
    logic signed [SUM_W-1:0]     win_sum;
    logic signed [SAMPLE_W-1:0]  win_min;
  } job_t;

endpackage

// ===== design/pcp_if.sv =====
`timescale 1ns / 1ps

interface pcp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcp_pkg::SAMPLE_W-1:0] sample;
  logic                                last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface pcp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcp_pkg::CHARGE_W-1:0] charge;
  logic signed [pcp_pkg::PEAK_W-1:0]   peak;
  logic [pcp_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output charge, output peak, output status, input ready);
  modport sink (input valid, input charge, input peak, input status, output ready);
endinterface

// ===== design/pulse_charge_and_peak.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload                        Transaction
// smp_i     in         sample, last_sample            one ADC sample of a waveform
// res_o     out        charge, peak, status           one result per waveform
// cfg_*     in         cfg_idx_i, cfg_data_i          register write when cfg_we_i is high
//
// The front takes one sample per cycle and stalls only while the two-entry job queue is full.
// In the back end a good result passes MUL, DIFF, ABS, the bit-serial DIV state and DONE.
// An error result skips the arithmetic; its job goes from IDLE straight to DONE.
// Reset is asynchronous and active low; it restores register defaults and clears the front's sums.
// A waiting result in the output register does not stop the back end from taking the next job.

`include "assert_macros.svh"

module pulse_charge_and_peak #(
  parameter int MAX_SAMPLES       = 1024,
  parameter int FALLBACK_PEDESTAL = 100
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pcp_in_if.sink                         smp_i,
  pcp_out_if.source                      res_o
);

  logic          q_push, q_pop, q_full, q_empty;
  pcp_pkg::job_t q_job_in, q_job_out;

  pcp_front #(
    .MAX_SAMPLES       (MAX_SAMPLES),
    .FALLBACK_PEDESTAL (FALLBACK_PEDESTAL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job_in)
  );

  pcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job_out),
    .empty_o (q_empty)
  );

  pcp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (q_job_out),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .res_o   (res_o)
  );

  `PCP_ASSERT_IMP(a_pop_has_job, q_pop, !q_empty)
  `PCP_ASSERT_NXT(a_one_job_at_a_time, q_pop, !q_pop)
  `PCP_ASSERT_IMP(a_error_zero, res_o.valid && res_o.status != pcp_pkg::STATUS_OK,
                  res_o.charge == '0 && res_o.peak == '0)

endmodule

// ===== design/pcp_front.sv =====
`timescale 1ns / 1ps

module pcp_front #(
  parameter int MAX_SAMPLES       = 1024,
  parameter int FALLBACK_PEDESTAL = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pcp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pcp_in_if.sink                           smp_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output pcp_pkg::job_t                    q_job_o
);

  localparam int IW    = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (IW > pcp_pkg::WEND_W) ? IW : pcp_pkg::WEND_W;
  localparam int FB_W  = pcp_pkg::SAMPLE_W + $clog2(FALLBACK_PEDESTAL + 1);
  localparam int SUM_W = pcp_pkg::SUM_W;

  logic [pcp_pkg::PCNT_W-1:0]   ped_count_q;
  logic [pcp_pkg::WFIRST_W-1:0] win_first_q;
  logic [pcp_pkg::WEND_W-1:0]   win_end_q;

  logic [IW-1:0]                         idx_q, idx_d;
  logic signed [SUM_W-1:0]               ped_sum_q, ped_sum_d;
  logic signed [FB_W-1:0]                fb_sum_q, fb_sum_d;
  logic signed [SUM_W-1:0]               win_sum_q, win_sum_d;
  logic signed [pcp_pkg::SAMPLE_W-1:0]   win_min_q, win_min_d;

  logic             accept;
  logic             in_range;
  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] len_x;
  logic             ped_hit, fb_hit, win_hit;
  logic             use_cfg;
  pcp_pkg::status_e status;

  assign smp_i.ready = !q_full_i;
  assign accept      = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_count_q <= pcp_pkg::PED_COUNT_RST;
      win_first_q <= pcp_pkg::WIN_FIRST_RST;
      win_end_q   <= pcp_pkg::WIN_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcp_pkg::REG_PED_COUNT: ped_count_q <= cfg_data_i[pcp_pkg::PCNT_W-1:0];
        pcp_pkg::REG_WIN_FIRST: win_first_q <= cfg_data_i[pcp_pkg::WFIRST_W-1:0];
        pcp_pkg::REG_WIN_END:   win_end_q   <= cfg_data_i[pcp_pkg::WEND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_range = idx_q < IW'(MAX_SAMPLES);
    idx_x    = CMP_W'(idx_q);
    ped_hit  = in_range && (idx_q != '0) && (idx_x <= CMP_W'(ped_count_q));
    fb_hit   = in_range && (idx_q != '0) && (idx_x <= CMP_W'(FALLBACK_PEDESTAL));
    win_hit  = in_range && (idx_x >= CMP_W'(win_first_q)) && (idx_x < CMP_W'(win_end_q));

    idx_d     = in_range ? idx_q + IW'(1) : idx_q;
    ped_sum_d = ped_sum_q + (ped_hit ? SUM_W'(smp_i.sample) : '0);
    fb_sum_d  = fb_sum_q + (fb_hit ? FB_W'(smp_i.sample) : '0);
    win_sum_d = win_sum_q + (win_hit ? SUM_W'(smp_i.sample) : '0);
    win_min_d = (win_hit && (smp_i.sample < win_min_q)) ? smp_i.sample : win_min_q;

    len_x   = CMP_W'(idx_d);
    use_cfg = (ped_count_q != '0) && (CMP_W'(ped_count_q) < len_x);
    if (!use_cfg && (len_x <= CMP_W'(FALLBACK_PEDESTAL))) begin
      status = pcp_pkg::STATUS_PEDESTAL;
    end else if ((pcp_pkg::WEND_W'(win_first_q) >= win_end_q) ||
                 (CMP_W'(win_end_q) > len_x)) begin
      status = pcp_pkg::STATUS_WINDOW;
    end else begin
      status = pcp_pkg::STATUS_OK;
    end

    q_job_o.status  = status;
    q_job_o.ped_n   = use_cfg ? ped_count_q : pcp_pkg::PCNT_W'(FALLBACK_PEDESTAL);
    q_job_o.ped_sum = use_cfg ? ped_sum_d : SUM_W'(fb_sum_d);
    q_job_o.win_len = win_end_q - pcp_pkg::WEND_W'(win_first_q);
    q_job_o.win_sum = win_sum_d;
    q_job_o.win_min = win_min_d;
  end

  assign q_push_o = accept && smp_i.last_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      ped_sum_q <= '0;
      fb_sum_q  <= '0;
      win_sum_q <= '0;
      win_min_q <= pcp_pkg::SAMPLE_MAX;
    end else if (accept) begin
      if (smp_i.last_sample) begin
        idx_q     <= '0;
        ped_sum_q <= '0;
        fb_sum_q  <= '0;
        win_sum_q <= '0;
        win_min_q <= pcp_pkg::SAMPLE_MAX;
      end else begin
        idx_q     <= idx_d;
        ped_sum_q <= ped_sum_d;
        fb_sum_q  <= fb_sum_d;
        win_sum_q <= win_sum_d;
        win_min_q <= win_min_d;
      end
    end
  end

endmodule

// ===== design/pcp_queue.sv =====
`timescale 1ns / 1ps

module pcp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcp_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output pcp_pkg::job_t job_o,
  output logic          empty_o
);

  pcp_pkg::job_t mem_q [pcp_pkg::QUEUE_DEPTH];

  logic [pcp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [pcp_pkg::QCNT_W-1:0] count_q;

  assign full_o  = count_q == pcp_pkg::QCNT_W'(pcp_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + pcp_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + pcp_pkg::QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + pcp_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - pcp_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/pcp_back.sv =====
`timescale 1ns / 1ps

module pcp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcp_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  pcp_out_if.source     res_o
);

  localparam int SUM_W = pcp_pkg::SUM_W;
  localparam int DIV_W = pcp_pkg::DIV_W;
  localparam int PWS_W = pcp_pkg::WEND_W + 1 + SUM_W;
  localparam int PWP_W = SUM_W + pcp_pkg::PCNT_W + 1;
  localparam int PMP_W = pcp_pkg::SAMPLE_W + pcp_pkg::PCNT_W + 1;
  localparam int DC_W  = PWS_W + 1;
  localparam int DP_W  = SUM_W + 1;
  localparam int REM_W = pcp_pkg::PCNT_W + 1;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] CHG_LIM = DIV_W'(1) << (pcp_pkg::CHARGE_W - 1);
  localparam logic [DIV_W-1:0] PK_LIM  = DIV_W'(1) << (pcp_pkg::PEAK_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  pcp_pkg::job_t            job_q;
  logic signed [PWS_W-1:0]  prod_ws_q;
  logic signed [PWP_W-1:0]  prod_wp_q;
  logic signed [PMP_W-1:0]  prod_mp_q;
  logic signed [DC_W-1:0]   diff_c_q;
  logic signed [DP_W-1:0]   diff_p_q;
  logic                     neg_c_q, neg_p_q;
  logic [DIV_W-1:0]         dvd_c_q, dvd_p_q;
  logic [REM_W-1:0]         rem_c_q, rem_p_q;
  logic [CNT_W-1:0]         cnt_q;

  logic                                out_valid_q;
  logic signed [pcp_pkg::CHARGE_W-1:0] charge_q;
  logic signed [pcp_pkg::PEAK_W-1:0]   peak_q;
  logic [pcp_pkg::STATUS_W-1:0]        status_q;

  logic [DC_W-1:0]  mag_c;
  logic [DP_W-1:0]  mag_p;
  logic [REM_W-1:0] divisor;
  logic [REM_W-1:0] rem_c_sh, rem_p_sh;
  logic             ge_c, ge_p;
  logic [DIV_W-1:0] neg_qc, neg_qp;
  logic signed [pcp_pkg::CHARGE_W-1:0] charge_d;
  logic signed [pcp_pkg::PEAK_W-1:0]   peak_d;
  logic             load_out;

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    mag_c   = diff_c_q[DC_W-1] ? DC_W'(-diff_c_q) : DC_W'(diff_c_q);
    mag_p   = diff_p_q[DP_W-1] ? DP_W'(-diff_p_q) : DP_W'(diff_p_q);
    divisor = REM_W'(job_q.ped_n);

    rem_c_sh = {rem_c_q[REM_W-2:0], dvd_c_q[DIV_W-1]};
    rem_p_sh = {rem_p_q[REM_W-2:0], dvd_p_q[DIV_W-1]};
    ge_c     = rem_c_sh >= divisor;
    ge_p     = rem_p_sh >= divisor;

    neg_qc = -dvd_c_q;
    neg_qp = -dvd_p_q;
    if (job_q.status != pcp_pkg::STATUS_OK) begin
      charge_d = '0;
    end else if (neg_c_q) begin
      charge_d = (dvd_c_q > CHG_LIM) ? pcp_pkg::CHARGE_W'(CHG_LIM)
                                     : pcp_pkg::CHARGE_W'(neg_qc);
    end else begin
      charge_d = (dvd_c_q >= CHG_LIM) ? pcp_pkg::CHARGE_W'(CHG_LIM - DIV_W'(1))
                                      : pcp_pkg::CHARGE_W'(dvd_c_q);
    end
    if (job_q.status != pcp_pkg::STATUS_OK) begin
      peak_d = '0;
    end else if (neg_p_q) begin
      peak_d = (dvd_p_q > PK_LIM) ? pcp_pkg::PEAK_W'(PK_LIM) : pcp_pkg::PEAK_W'(neg_qp);
    end else begin
      peak_d = (dvd_p_q >= PK_LIM) ? pcp_pkg::PEAK_W'(PK_LIM - DIV_W'(1))
                                   : pcp_pkg::PEAK_W'(dvd_p_q);
    end
  end

  // Arithmetic datapath; MUL, DIFF, ABS and DIV step it.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          job_q <= job_i;
        end
      end
      ST_MUL: begin
        prod_ws_q <= PWS_W'($signed({1'b0, job_q.win_len})) * PWS_W'(job_q.ped_sum);
        prod_wp_q <= PWP_W'(job_q.win_sum) * PWP_W'($signed({1'b0, job_q.ped_n}));
        prod_mp_q <= PMP_W'(job_q.win_min) * PMP_W'($signed({1'b0, job_q.ped_n}));
      end
      ST_DIFF: begin
        diff_c_q <= DC_W'(prod_ws_q) - DC_W'(prod_wp_q);
        diff_p_q <= DP_W'(job_q.ped_sum) - DP_W'(prod_mp_q);
      end
      ST_ABS: begin
        neg_c_q <= diff_c_q[DC_W-1];
        neg_p_q <= diff_p_q[DP_W-1];
        dvd_c_q <= DIV_W'({mag_c, 8'b0}) + DIV_W'(job_q.ped_n >> 1);
        dvd_p_q <= DIV_W'({mag_p, 8'b0}) + DIV_W'(job_q.ped_n >> 1);
        rem_c_q <= '0;
        rem_p_q <= '0;
      end
      ST_DIV: begin
        rem_c_q <= ge_c ? rem_c_sh - divisor : rem_c_sh;
        rem_p_q <= ge_p ? rem_p_sh - divisor : rem_p_sh;
        dvd_c_q <= {dvd_c_q[DIV_W-2:0], ge_c};
        dvd_p_q <= {dvd_p_q[DIV_W-2:0], ge_p};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      charge_q    <= '0;
      peak_q      <= '0;
      status_q    <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        charge_q    <= charge_d;
        peak_q      <= peak_d;
        status_q    <= job_q.status;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            state_q <= (job_i.status == pcp_pkg::STATUS_OK) ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL:  state_q <= ST_DIFF;
        ST_DIFF: state_q <= ST_ABS;
        ST_ABS: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.charge = charge_q;
  assign res_o.peak   = peak_q;
  assign res_o.status = status_q;

endmodule

// ===== sim/pulse_charge_and_peak_tb.sv =====
`timescale 1ns / 1ps

module pulse_charge_and_peak_tb;

  localparam int FALLBACK_COUNT = 100;
  localparam int SAMPLE_LIMIT   = 1024;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_SAMPLES = 1700;
  localparam int MODE_RESULTS   = 4;
  localparam int MAX_REPORTS    = 10;
  localparam longint CHARGE_LIM = (longint'(1) << (pcp_pkg::CHARGE_W - 1)) - 1;
  localparam longint PEAK_LIM   = (longint'(1) << (pcp_pkg::PEAK_W - 1)) - 1;

  typedef struct packed {
    logic signed [pcp_pkg::CHARGE_W-1:0] charge;
    logic signed [pcp_pkg::PEAK_W-1:0]   peak;
    pcp_pkg::status_e                    status;
  } pulse_result_t;

  typedef struct packed {
    int                                  ped_count;
    int                                  win_first;
    int                                  win_end;
    logic signed [pcp_pkg::SAMPLE_W-1:0] sample;
    bit                                  last;
    bit                                  known;
    longint                              charge;
    longint                              peak;
    pcp_pkg::status_e                    status;
  } stim_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [pcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [pcp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  pcp_in_if  smp_if ();
  pcp_out_if res_if ();

  pulse_charge_and_peak DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp_if),
    .res_o      (res_if)
  );

  stim_row_t directed_rows [22] = '{
    '{100, 150, 350, 16'sh1234, 1'b1, 1'b1, 64'sd0, 64'sd0, pcp_pkg::STATUS_PEDESTAL},
    '{2, 3, 5, 16'sh8000, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh7fff, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh7fff, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh8000, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh8000, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh0000, 1'b1, 1'b1, 64'sd33553920, 64'sd16776960, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh0064, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'shff9c, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh0007, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{2, 3, 5, 16'sh0009, 1'b1, 1'b1, 64'sd0, 64'sd0, pcp_pkg::STATUS_WINDOW},
    '{0, 3, 3, 16'sh0001, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{0, 3, 3, 16'sh0002, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{0, 3, 3, 16'sh0003, 1'b1, 1'b1, 64'sd0, 64'sd0, pcp_pkg::STATUS_PEDESTAL},
    '{1, 3, 2, 16'sh0005, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{1, 3, 2, 16'sh0006, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{1, 3, 2, 16'sh0007, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{1, 3, 2, 16'sh0008, 1'b1, 1'b1, 64'sd0, 64'sd0, pcp_pkg::STATUS_WINDOW},
    '{3, 0, 4, 16'sh000a, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{3, 0, 4, 16'sh0001, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{3, 0, 4, 16'sh0001, 1'b0, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK},
    '{3, 0, 4, 16'sh0002, 1'b1, 1'b0, 64'sd0, 64'sd0, pcp_pkg::STATUS_OK}
  };

  int cfg_ped_count;
  int cfg_win_first;
  int cfg_win_end;

  int     wf_index;
  longint ped_acc;
  longint fb_acc;
  longint win_acc;
  int     win_low;

  pulse_result_t pending_results [$];

  int mismatches;
  int results_seen;
  int samples_sent;
  int src_idle_pct;
  int sink_idle_pct;
  bit hold_go;
  bit hold_seen;
  int hold_left;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic void restart_waveform();
    wf_index = 0;
    ped_acc = 0;
    fb_acc = 0;
    win_acc = 0;
    win_low = int'(pcp_pkg::SAMPLE_MAX);
  endfunction

  function automatic bit fold_sample(input int x, input bit last, output pulse_result_t expected);
    int               len;
    int               p;
    longint           s;
    longint           w;
    longint           charge;
    longint           peak;
    pcp_pkg::status_e st;
    expected = '0;
    if (wf_index < SAMPLE_LIMIT) begin
      if (wf_index >= 1 && wf_index <= cfg_ped_count) ped_acc += longint'(x);
      if (wf_index >= 1 && wf_index <= FALLBACK_COUNT) fb_acc += longint'(x);
      if (wf_index >= cfg_win_first && wf_index < cfg_win_end) begin
        win_acc += longint'(x);
        if (x < win_low) win_low = x;
      end
      wf_index++;
    end
    if (!last) return 1'b0;
    len = wf_index;
    st = pcp_pkg::STATUS_OK;
    if (cfg_ped_count != 0 && cfg_ped_count < len) begin
      p = cfg_ped_count;
      s = ped_acc;
    end else begin
      p = FALLBACK_COUNT;
      s = fb_acc;
      if (len <= FALLBACK_COUNT) st = pcp_pkg::STATUS_PEDESTAL;
    end
    if (st == pcp_pkg::STATUS_OK && (cfg_win_first >= cfg_win_end || cfg_win_end > len)) begin
      st = pcp_pkg::STATUS_WINDOW;
    end
    charge = 0;
    peak = 0;
    if (st == pcp_pkg::STATUS_OK) begin
      w = longint'(cfg_win_end - cfg_win_first);
      charge = clamp_to(round_div(256 * (w * s - win_acc * p), p), CHARGE_LIM);
      peak = clamp_to(round_div(256 * (s - longint'(win_low) * p), p), PEAK_LIM);
    end
    expected.charge = pcp_pkg::CHARGE_W'(charge);
    expected.peak = pcp_pkg::PEAK_W'(peak);
    expected.status = st;
    restart_waveform();
    return 1'b1;
  endfunction

  function automatic logic signed [pcp_pkg::SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(99);
    if (r < 65) return pcp_pkg::SAMPLE_W'($urandom);
    if (r < 85) return pcp_pkg::SAMPLE_W'($urandom_range(100) - 50);
    if (r < 93) return pcp_pkg::SAMPLE_MAX;
    return ~pcp_pkg::SAMPLE_MAX;
  endfunction

  function automatic int pick_length();
    if ($urandom_range(99) < 80) return $urandom_range(24, 1);
    return $urandom_range(130, 101);
  endfunction

  task automatic write_reg(input logic [pcp_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[pcp_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_config(input int pc, input int wf, input int we);
    write_reg(pcp_pkg::REG_PED_COUNT, pc);
    write_reg(pcp_pkg::REG_WIN_FIRST, wf);
    write_reg(pcp_pkg::REG_WIN_END, we);
    cfg_ped_count = pc;
    cfg_win_first = wf;
    cfg_win_end = we;
  endtask

  task automatic settle();
    smp_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic signed [pcp_pkg::SAMPLE_W-1:0] x, input bit last,
                             input bit known, input pulse_result_t typed);
    pulse_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.sample <= x;
    smp_if.last_sample <= last;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
    samples_sent++;
    if (fold_sample(int'(x), last, predicted)) begin
      pending_results.insert(pending_results.size(), known ? typed : predicted);
    end
  endtask

  task automatic send_waveform(input int len);
    for (int i = 0; i < len; i++) begin
      push_sample(random_sample(), i == len - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    pulse_result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: charge %0d peak %0d status %0d",
                   res_if.charge, res_if.peak, res_if.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (res_if.charge !== want.charge || res_if.peak !== want.peak
            || res_if.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: expected charge %0d peak %0d status %0d, got %0d %0d %0d",
                     results_seen, want.charge, want.peak, want.status,
                     res_if.charge, res_if.peak, res_if.status);
          end
        end
      end
      results_seen++;
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL pulse_charge_and_peak");
    $finish;
  end

  initial begin
    int            r;
    int            pc;
    int            wf;
    int            we;
    int            mode_start;
    bit            wf_start;
    pulse_result_t typed;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pcp_pkg::REG_PED_COUNT;
    cfg_data_i = '0;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    smp_if.last_sample = 1'b0;
    hold_go = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    mismatches = 0;
    results_seen = 0;
    samples_sent = 0;
    cfg_ped_count = int'(pcp_pkg::PED_COUNT_RST);
    cfg_win_first = int'(pcp_pkg::WIN_FIRST_RST);
    cfg_win_end = int'(pcp_pkg::WIN_END_RST);
    restart_waveform();
    src_idle_pct = 36;
    sink_idle_pct = 58;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wf_start = 1'b1;
    for (int i = 0; i < $size(directed_rows); i++) begin
      if (wf_start && (directed_rows[i].ped_count != cfg_ped_count
                       || directed_rows[i].win_first != cfg_win_first
                       || directed_rows[i].win_end != cfg_win_end)) begin
        settle();
        load_config(directed_rows[i].ped_count, directed_rows[i].win_first,
                    directed_rows[i].win_end);
      end
      typed.charge = pcp_pkg::CHARGE_W'(directed_rows[i].charge);
      typed.peak = pcp_pkg::PEAK_W'(directed_rows[i].peak);
      typed.status = directed_rows[i].status;
      push_sample(directed_rows[i].sample, directed_rows[i].last, directed_rows[i].known, typed);
      wf_start = directed_rows[i].last;
    end

    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 58 : 0;
      sink_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 36 : 0;
      mode_start = results_seen;
      settle();
      if (mode == 0) begin
        load_config(SAMPLE_LIMIT - 1, 0, SAMPLE_LIMIT);
        send_waveform(SAMPLE_LIMIT + 6);
      end else if (mode == 1) begin
        load_config(120, 0, $urandom_range(121, 1));
        repeat (2) send_waveform($urandom_range(140, 121));
      end else begin
        load_config(2, 1, 6);
        @(negedge clk_i);
        hold_go = ~hold_go;
        @(posedge clk_i);
        repeat (12) send_waveform(8);
      end
      while (samples_sent < RANDOM_SAMPLES * (mode + 1) / 3
             || results_seen - mode_start < MODE_RESULTS) begin
        r = $urandom_range(99);
        pc = (r < 10) ? 0 : (r < 15) ? SAMPLE_LIMIT - 1 : (r < 20) ? FALLBACK_COUNT
           : $urandom_range(12, 1);
        r = $urandom_range(99);
        wf = (r < 8) ? SAMPLE_LIMIT - 1 : $urandom_range(16, 0);
        r = $urandom_range(99);
        we = (r < 8) ? SAMPLE_LIMIT : (r < 15) ? $urandom_range(wf, 0)
           : wf + $urandom_range(10, 1);
        if (we > SAMPLE_LIMIT) we = SAMPLE_LIMIT;
        settle();
        load_config(pc, wf, we);
        repeat ($urandom_range(6, 2)) send_waveform(pick_length());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS pulse_charge_and_peak");
    end else begin
      $display("FAIL pulse_charge_and_peak");
    end
    $finish;
  end

endmodule
